>>> rtl/sttc_pkg.sv
`timescale 1ns / 1ps

package sttc_pkg;

   localparam int INPUT_WIDTH = 15;
   // A share scaled by 100 stays below 2^22.
   localparam int POINT_WIDTH = INPUT_WIDTH + 7;
   localparam int CLASS_WIDTH = 4;
   localparam int PCT_WIDTH = 7;
   localparam int DIFF_WIDTH = PCT_WIDTH + 1;
   localparam int DEFAULT_FRACTION_BITS = 8;
   localparam int TRI_COUNT = 29;
   localparam int TRI_IDX_WIDTH = $clog2(TRI_COUNT);
   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CLASS_WIDTH-1:0] NO_CLASS = 4'd12;
   localparam logic [TRI_IDX_WIDTH-1:0] LAST_TRI = TRI_IDX_WIDTH'(TRI_COUNT - 1);

   typedef logic [PCT_WIDTH-1:0] pct_type;
   // Element 0 is sand, 1 is clay, 2 is silt, in whole percent.
   typedef pct_type [0:2] vertex_type;

   localparam vertex_type TRI_ROM [TRI_COUNT][3] = '{
      '{'{0, 100, 0}, '{0, 60, 40}, '{20, 40, 40}},
      '{'{0, 100, 0}, '{20, 40, 40}, '{50, 40, 10}},
      '{'{0, 100, 0}, '{50, 40, 10}, '{50, 50, 0}},
      '{'{50, 50, 0}, '{50, 35, 15}, '{65, 35, 0}},
      '{'{0, 60, 40}, '{0, 40, 60}, '{20, 40, 40}},
      '{'{65, 35, 0}, '{50, 35, 15}, '{50, 30, 20}},
      '{'{65, 35, 0}, '{50, 30, 20}, '{55, 25, 20}},
      '{'{65, 35, 0}, '{55, 25, 20}, '{75, 25, 0}},
      '{'{20, 40, 40}, '{20, 30, 50}, '{50, 30, 20}},
      '{'{20, 40, 40}, '{50, 30, 20}, '{10, 50, 40}},
      '{'{0, 40, 60}, '{0, 30, 70}, '{20, 30, 50}},
      '{'{0, 40, 60}, '{20, 30, 50}, '{20, 40, 40}},
      '{'{85, 15, 0}, '{85, 0, 15}, '{100, 0, 0}},
      '{'{80, 20, 0}, '{70, 0, 30}, '{85, 0, 15}},
      '{'{80, 20, 0}, '{85, 0, 15}, '{85, 15, 0}},
      '{'{55, 10, 35}, '{40, 10, 50}, '{50, 0, 50}},
      '{'{55, 10, 35}, '{50, 0, 50}, '{70, 0, 30}},
      '{'{55, 10, 35}, '{70, 0, 30}, '{80, 20, 0}},
      '{'{55, 10, 35}, '{80, 20, 0}, '{75, 25, 0}},
      '{'{55, 10, 35}, '{75, 25, 0}, '{55, 25, 20}},
      '{'{50, 30, 20}, '{20, 30, 50}, '{40, 10, 50}},
      '{'{50, 30, 20}, '{40, 10, 50}, '{55, 10, 35}},
      '{'{50, 30, 20}, '{55, 10, 35}, '{55, 25, 15}},
      '{'{15, 10, 75}, '{25, 0, 75}, '{50, 0, 50}},
      '{'{15, 10, 75}, '{50, 0, 50}, '{20, 30, 50}},
      '{'{15, 10, 75}, '{20, 30, 50}, '{0, 30, 70}},
      '{'{15, 10, 75}, '{0, 30, 70}, '{0, 10, 90}},
      '{'{15, 10, 75}, '{0, 10, 90}, '{0, 0, 100}},
      '{'{15, 10, 75}, '{0, 0, 100}, '{25, 0, 75}}
   };

   localparam logic [CLASS_WIDTH-1:0] TRI_CLASS [TRI_COUNT] = '{
      4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
      4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11
   };

endpackage

>>> rtl/soil_texture_triangle_classifier.sv
`timescale 1ns / 1ps
// Channel   Dir  Ports                       Word
// req       in   req_tvalid/tready/tdata     sand, clay, silt shares (15 bits each)
// rsp       out  rsp_tvalid/tready/tdata     texture class (4 bits)
//
// One word takes a load step, then tests the triangles in order, edge by edge,
// on one shared edge cross-product unit, until one matches or the last is done.
// The block takes one word at a time and is ready again once the result has
// moved into the output register, even while that result waits.
// Reset is synchronous and active high; it clears the sequencer and the output
// valid. A stalled result holds the sequencer until the output register frees.

module soil_texture_triangle_classifier #(
   parameter int FRACTION_BITS = sttc_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [14:0] sand_share, [29:15] clay_share, [44:30] silt_share, [47:45] zero
   input  logic [sttc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [3:0] texture_class, [7:4] zero
   output logic [sttc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int IW = sttc_pkg::INPUT_WIDTH;
   localparam int PW = sttc_pkg::POINT_WIDTH;
   localparam int CW = sttc_pkg::CLASS_WIDTH;
   localparam int DW = sttc_pkg::DIFF_WIDTH;
   localparam int TW = sttc_pkg::TRI_IDX_WIDTH;
   localparam int VW = sttc_pkg::PCT_WIDTH + FRACTION_BITS;
   localparam int RW = ((PW > VW) ? PW : VW) + 1;
   localparam int PRW = RW + DW;
   localparam int XW = PRW + 1;
   localparam int SW = (((IW + 2) > (4 + FRACTION_BITS)) ? (IW + 2) : (4 + FRACTION_BITS)) + 1;
   localparam logic [SW-1:0] FRAC_LIMIT = SW'(10) << FRACTION_BITS;
   localparam logic signed [XW-1:0] ONE = XW'(1) << FRACTION_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [TW-1:0] tri_ff, tri_in;
   logic [1:0]    side_ff, side_in;
   logic [2:0]    ge_ff, ge_in;
   logic [2:0]    le_ff, le_in;
   logic [PW-1:0] point_ff [3];
   logic [PW-1:0] point_in [3];
   logic [CW-1:0] cls_ff, cls_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_class_ff, rsp_class_in;

   logic [IW-1:0]  share [3];
   logic [SW-1:0]  share_sum;
   logic           as_fraction;
   logic           req_fire;
   logic           out_free;

   sttc_pkg::vertex_type vert_a, vert_b;
   logic [1:0]           side_next;
   logic [2:0]           ge_now, le_now, ge_all, le_all;
   logic                 tri_hit;
   logic                 finish;
   logic [CW-1:0]        found_class;

   assign share[0] = req_tdata[IW-1:0];
   assign share[1] = req_tdata[2*IW-1:IW];
   assign share[2] = req_tdata[3*IW-1:2*IW];

   assign share_sum = SW'(share[0]) + SW'(share[1]) + SW'(share[2]);
   assign as_fraction = share_sum <= FRAC_LIMIT;

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Shared unit: one edge of the current triangle per cycle. The edge vector
   // is whole percent, so the 2^FRACTION_BITS factor cancels from the test.
   assign side_next = (side_ff == 2'd2) ? 2'd0 : side_ff + 2'd1;
   assign vert_a = sttc_pkg::TRI_ROM[tri_ff][side_ff];
   assign vert_b = sttc_pkg::TRI_ROM[tri_ff][side_next];

   logic signed [RW-1:0] rel [3];
   logic signed [DW-1:0] dir [3];

   for (genvar j = 0; j < 3; j++) begin : g_axis
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      logic [RW-1:0]         vert_scaled;
      logic signed [PRW-1:0] prod_a, prod_b;
      logic signed [XW-1:0]  comp;

      assign vert_scaled = RW'(vert_a[j]) << FRACTION_BITS;
      assign rel[j] = $signed(RW'(point_ff[j]) - vert_scaled);
      assign dir[j] = $signed({1'b0, vert_b[j]}) - $signed({1'b0, vert_a[j]});
      assign prod_a = rel[J1] * dir[J2];
      assign prod_b = rel[J2] * dir[J1];
      assign comp = XW'(prod_a) - XW'(prod_b);
      assign ge_now[j] = comp > -ONE;
      assign le_now[j] = comp < ONE;
   end

   assign ge_all = ((side_ff == 2'd0) ? 3'b111 : ge_ff) & ge_now;
   assign le_all = ((side_ff == 2'd0) ? 3'b111 : le_ff) & le_now;
   // All axes score +1, or all score -1 (an axis that passes both counts +1).
   assign tri_hit = (&ge_all) || (&(le_all & ~ge_all));
   assign finish = (side_ff == 2'd2) && (tri_hit || (tri_ff == sttc_pkg::LAST_TRI));
   assign found_class = tri_hit ? sttc_pkg::TRI_CLASS[tri_ff] : sttc_pkg::NO_CLASS;

   always_comb begin
      state_in = state_ff;
      tri_in = tri_ff;
      side_in = side_ff;
      ge_in = ge_ff;
      le_in = le_ff;
      point_in = point_ff;
      cls_in = cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_class_in = rsp_class_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int j = 0; j < 3; j++) begin
                  if (as_fraction) begin
                     point_in[j] = (PW'(share[j]) << 6) + (PW'(share[j]) << 5)
                                   + (PW'(share[j]) << 2);
                  end else begin
                     point_in[j] = PW'(share[j]);
                  end
               end
               tri_in = '0;
               side_in = 2'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ge_in = ge_all;
            le_in = le_all;
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_class_in = found_class;
                  state_in = ST_IDLE;
               end else begin
                  cls_in = found_class;
                  state_in = ST_DONE;
               end
            end else if (side_ff == 2'd2) begin
               side_in = 2'd0;
               tri_in = tri_ff + TW'(1);
            end else begin
               side_in = side_next;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = cls_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tri_ff <= tri_in;
      side_ff <= side_in;
      ge_ff <= ge_in;
      le_ff <= le_in;
      point_ff <= point_in;
      cls_ff <= cls_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(sttc_pkg::RSP_DATA_WIDTH - CW)'(0), rsp_class_ff};

endmodule

>>> rtl/sttc_checker.sv
`timescale 1ns / 1ps

module sttc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [sttc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sttc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   logic [sttc_pkg::REQ_DATA_WIDTH-1:0] req_seen;
   assign req_seen = req_tdata;

   // A waiting result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= sttc_pkg::NO_CLASS && rsp_tdata[7:4] == 4'd0)
      else $error("result class out of range");

   // The search runs in the scan state, so the block is busy after taking a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting a word");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !$isunknown(req_seen) |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after accept");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind soil_texture_triangle_classifier sttc_checker u_sttc_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC_BITS = sttc_pkg::DEFAULT_FRACTION_BITS;
   localparam int PCT = 1 << FRAC_BITS;
   localparam int FAN_COUNT = 29;
   localparam int RANDOM_WORDS = 1500;
   localparam int LONG_HOLD = 250;
   localparam int SETTLE_CYCLES = 100;
   localparam int STALL_LIMIT = 3000;

   typedef enum logic [3:0] {
      TEX_CLAY, TEX_SANDY_CLAY, TEX_SILTY_CLAY, TEX_SANDY_CLAY_LOAM, TEX_CLAY_LOAM,
      TEX_SILTY_CLAY_LOAM, TEX_SAND, TEX_LOAMY_SAND, TEX_SANDY_LOAM, TEX_LOAM,
      TEX_SILT_LOAM, TEX_SILT, TEX_UNCLASSIFIED
   } texture_type;

   // Corners of each fan triangle in whole percent, sand/clay/silt per corner.
   localparam int FAN_CORNERS [FAN_COUNT][9] = '{
      '{0, 100, 0, 0, 60, 40, 20, 40, 40},
      '{0, 100, 0, 20, 40, 40, 50, 40, 10},
      '{0, 100, 0, 50, 40, 10, 50, 50, 0},
      '{50, 50, 0, 50, 35, 15, 65, 35, 0},
      '{0, 60, 40, 0, 40, 60, 20, 40, 40},
      '{65, 35, 0, 50, 35, 15, 50, 30, 20},
      '{65, 35, 0, 50, 30, 20, 55, 25, 20},
      '{65, 35, 0, 55, 25, 20, 75, 25, 0},
      '{20, 40, 40, 20, 30, 50, 50, 30, 20},
      '{20, 40, 40, 50, 30, 20, 10, 50, 40},
      '{0, 40, 60, 0, 30, 70, 20, 30, 50},
      '{0, 40, 60, 20, 30, 50, 20, 40, 40},
      '{85, 15, 0, 85, 0, 15, 100, 0, 0},
      '{80, 20, 0, 70, 0, 30, 85, 0, 15},
      '{80, 20, 0, 85, 0, 15, 85, 15, 0},
      '{55, 10, 35, 40, 10, 50, 50, 0, 50},
      '{55, 10, 35, 50, 0, 50, 70, 0, 30},
      '{55, 10, 35, 70, 0, 30, 80, 20, 0},
      '{55, 10, 35, 80, 20, 0, 75, 25, 0},
      '{55, 10, 35, 75, 25, 0, 55, 25, 20},
      '{50, 30, 20, 20, 30, 50, 40, 10, 50},
      '{50, 30, 20, 40, 10, 50, 55, 10, 35},
      '{50, 30, 20, 55, 10, 35, 55, 25, 15},
      '{15, 10, 75, 25, 0, 75, 50, 0, 50},
      '{15, 10, 75, 50, 0, 50, 20, 30, 50},
      '{15, 10, 75, 20, 30, 50, 0, 30, 70},
      '{15, 10, 75, 0, 30, 70, 0, 10, 90},
      '{15, 10, 75, 0, 10, 90, 0, 0, 100},
      '{15, 10, 75, 0, 0, 100, 25, 0, 75}
   };

   localparam logic [3:0] FAN_CLASS [FAN_COUNT] = '{
      TEX_CLAY, TEX_CLAY, TEX_CLAY, TEX_SANDY_CLAY, TEX_SILTY_CLAY,
      TEX_SANDY_CLAY_LOAM, TEX_SANDY_CLAY_LOAM, TEX_SANDY_CLAY_LOAM,
      TEX_CLAY_LOAM, TEX_CLAY_LOAM, TEX_SILTY_CLAY_LOAM, TEX_SILTY_CLAY_LOAM,
      TEX_SAND, TEX_LOAMY_SAND, TEX_LOAMY_SAND,
      TEX_SANDY_LOAM, TEX_SANDY_LOAM, TEX_SANDY_LOAM, TEX_SANDY_LOAM, TEX_SANDY_LOAM,
      TEX_LOAM, TEX_LOAM, TEX_LOAM,
      TEX_SILT_LOAM, TEX_SILT_LOAM, TEX_SILT_LOAM, TEX_SILT_LOAM, TEX_SILT, TEX_SILT
   };

   typedef struct packed {
      logic [14:0] sand;
      logic [14:0] clay;
      logic [14:0] silt;
      logic        typed;
      logic [3:0]  cls;
   } share_row_type;

   // Rows with typed set carry a class that is plain from the geometry.
   share_row_type directed_rows [0:23] = '{
      '{15'd0, 15'd0, 15'd0, 1'b0, TEX_UNCLASSIFIED},
      '{15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0, TEX_UNCLASSIFIED},
      '{15'h7FFF, 15'd0, 15'd0, 1'b0, TEX_UNCLASSIFIED},
      '{15'd0, 15'h7FFF, 15'd0, 1'b0, TEX_UNCLASSIFIED},
      '{15'd0, 15'd0, 15'h7FFF, 1'b0, TEX_UNCLASSIFIED},
      '{15'd1280, 15'd768, 15'd512, 1'b0, TEX_UNCLASSIFIED},
      '{15'd1281, 15'd768, 15'd512, 1'b0, TEX_UNCLASSIFIED},
      '{15'(5 * PCT), 15'(80 * PCT), 15'(15 * PCT), 1'b1, TEX_CLAY},
      '{15'(95 * PCT), 15'(2 * PCT), 15'(3 * PCT), 1'b1, TEX_SAND},
      '{15'(5 * PCT), 15'(5 * PCT), 15'(90 * PCT), 1'b1, TEX_SILT},
      '{15'(52 * PCT), 15'(42 * PCT), 15'(6 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(8 * PCT), 15'(48 * PCT), 15'(44 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(60 * PCT), 15'(28 * PCT), 15'(12 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(32 * PCT), 15'(34 * PCT), 15'(34 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(10 * PCT), 15'(34 * PCT), 15'(56 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(82 * PCT), 15'(8 * PCT), 15'(10 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(65 * PCT), 15'(10 * PCT), 15'(25 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(40 * PCT), 15'(20 * PCT), 15'(40 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'(20 * PCT), 15'(10 * PCT), 15'(70 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'd102, 15'd51, 15'd102, 1'b0, TEX_UNCLASSIFIED},
      '{15'(50 * PCT), 15'd0, 15'(50 * PCT), 1'b0, TEX_UNCLASSIFIED},
      '{15'd0, 15'(100 * PCT), 15'd0, 1'b0, TEX_UNCLASSIFIED},
      '{15'(100 * PCT), 15'd0, 15'd0, 1'b0, TEX_UNCLASSIFIED},
      '{15'd0, 15'd0, 15'(100 * PCT), 1'b0, TEX_UNCLASSIFIED}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [sttc_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sttc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;

   bit         req_taken;
   bit         rsp_taken;
   bit         row_typed;
   logic [3:0] row_class = TEX_UNCLASSIFIED;
   bit         burst_mode;
   bit         long_hold_req;
   int         idle_cycles;
   int         mismatch_count;
   int         result_index;
   logic [3:0] expected_class;
   logic [3:0] expected_classes [$];

   soil_texture_triangle_classifier #(
      .FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Finds the first fan triangle that holds the point, after scaling fractions to percent.
   function automatic logic [3:0] predict_texture(input logic [14:0] sand, clay, silt);
      longint pt [3];
      longint corner [3][3];
      longint rel [3];
      longint side [3];
      longint cp [3][3];
      longint unit;
      int     t, i, j, n, score;
      bit     all_ge, all_le;
      pt[0] = longint'(sand);
      pt[1] = longint'(clay);
      pt[2] = longint'(silt);
      if (pt[0] + pt[1] + pt[2] <= (longint'(10) << FRAC_BITS)) begin
         for (i = 0; i < 3; i++) pt[i] = pt[i] * 100;
      end
      unit = longint'(1) << (2 * FRAC_BITS);
      for (t = 0; t < FAN_COUNT; t++) begin
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++) corner[i][j] = longint'(FAN_CORNERS[t][3*i+j]) << FRAC_BITS;
         for (i = 0; i < 3; i++) begin
            n = (i + 1) % 3;
            for (j = 0; j < 3; j++) begin
               rel[j] = pt[j] - corner[i][j];
               side[j] = corner[n][j] - corner[i][j];
            end
            cp[i][0] = rel[1] * side[2] - rel[2] * side[1];
            cp[i][1] = rel[2] * side[0] - rel[0] * side[2];
            cp[i][2] = rel[0] * side[1] - rel[1] * side[0];
         end
         score = 0;
         // A component counts as non-negative when it truncates to zero or more.
         for (j = 0; j < 3; j++) begin
            all_ge = 1'b1;
            all_le = 1'b1;
            for (i = 0; i < 3; i++) begin
               if (!(cp[i][j] > -unit)) all_ge = 1'b0;
               if (!(cp[i][j] < unit)) all_le = 1'b0;
            end
            if (all_ge) score++;
            else if (all_le) score--;
         end
         if (score == 3 || score == -3) return FAN_CLASS[t];
      end
      return TEX_UNCLASSIFIED;
   endfunction

   // Mostly shares on the texture plane, in percent or as fractions, some snapped to the
   // grid of triangle corners, some near the fraction threshold, the rest raw noise.
   function automatic logic [47:0] draw_share_word();
      int pick, total, a, b, k, jit, rot;
      int part [3];
      pick = $urandom_range(99, 0);
      if (pick >= 85) begin
         return {3'b000, 15'($urandom), 15'($urandom), 15'($urandom)};
      end
      if (pick < 55 || pick >= 75) begin
         if (pick < 40) total = 100 << FRAC_BITS;
         else if (pick < 55) total = 1 << FRAC_BITS;
         else total = (10 << FRAC_BITS) - 8 + $urandom_range(16, 0);
         a = $urandom_range(total, 0);
         b = $urandom_range(total - a, 0);
         part[0] = a;
         part[1] = b;
         part[2] = total - a - b;
      end else begin
         a = 5 * $urandom_range(20, 0);
         b = 5 * $urandom_range((100 - a) / 5, 0);
         part[0] = a << FRAC_BITS;
         part[1] = b << FRAC_BITS;
         part[2] = (100 - a - b) << FRAC_BITS;
         for (k = 0; k < 3; k++) begin
            if ($urandom_range(1, 0) == 1) begin
               jit = $urandom_range(4, 0);
               part[k] = part[k] + jit - 2;
               if (part[k] < 0) part[k] = 0;
            end
         end
      end
      rot = $urandom_range(2, 0);
      return {3'b000, 15'(part[(rot + 2) % 3]), 15'(part[(rot + 1) % 3]), 15'(part[rot])};
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic offer_share(input logic [47:0] word, input bit typed, input logic [3:0] cls);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(13, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= word;
      row_typed <= typed;
      row_class <= cls;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_taken);
   endtask

   // The word just taken must not be offered again while the block drains.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_classes.size() != 0);
   endtask

   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      idle_cycles <= (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (row_typed) expected_classes.push_back(row_class);
         else expected_classes.push_back(predict_texture(req_tdata[14:0], req_tdata[29:15],
                                                         req_tdata[44:30]));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_classes.size() == 0) begin
            report_mismatch($sformatf("result %0d: class %0d arrived with nothing expected",
                                      result_index, rsp_tdata[3:0]));
         end else begin
            expected_class = expected_classes.pop_front();
            if (rsp_tdata[3:0] !== expected_class)
               report_mismatch($sformatf("result %0d: texture_class expected %0d got %0d",
                                         result_index, expected_class, rsp_tdata[3:0]));
         end
         result_index++;
      end
   end

   // Result side: random stalls per word, plus one long hold-off when asked.
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            stall = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            stall = burst_mode ? 0 : $urandom_range(13, 0);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_taken);
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (r = 0; r < 24; r++) begin
         offer_share({3'b000, directed_rows[r].silt, directed_rows[r].clay,
                      directed_rows[r].sand}, directed_rows[r].typed, directed_rows[r].cls);
      end
      for (r = 0; r < RANDOM_WORDS; r++) begin
         // Every fourth stretch of 150 words runs both sides without idling.
         burst_mode = ((r / 150) % 4) == 3;
         if (r == 500) long_hold_req = 1'b1;
         if (r == 1000) wait_drained();
         offer_share(draw_share_word(), 1'b0, TEX_UNCLASSIFIED);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_classes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
